/* rtl/bms_status_frame_decoder_top_assert.svh */
// Assertion macros shared by the decoder RTL.
`ifndef BMS_STATUS_FRAME_DECODER_TOP_ASSERT_SVH
`define BMS_STATUS_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define BMSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmsd assertion failed");

// Next-cycle implication.
`define BMSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmsd assertion failed");

`endif

/* rtl/bmsd_pkg.sv */
// ----------------------------------------------------------------------------
// bmsd_pkg
// Types, codes and constants of the status frame decoder.
// ----------------------------------------------------------------------------
package bmsd_pkg;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_INFO    = 3'd1,
    STAT_FRAMING = 3'd2,
    STAT_CRC     = 3'd3,
    STAT_UNKNOWN = 3'd4,
    STAT_DECODE  = 3'd5
  } status_e;

  localparam logic [7:0]  SOF0_BYTE   = 8'h7E;
  localparam logic [7:0]  SOF1_BYTE   = 8'hA1;
  localparam logic [15:0] EOF_WORD    = 16'hAA55;
  localparam logic [7:0]  TYPE_STATUS = 8'h11;
  localparam logic [7:0]  TYPE_INFO   = 8'h12;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam int unsigned MAX_CELLS        = 32;
  localparam int unsigned MAX_TEMP_SENSORS = 4;
  localparam int unsigned TEMP_SLOTS       = 4;
  localparam int unsigned HDR_LEN          = 10;
  localparam int unsigned MIN_STATUS_LEN   = 86;
  localparam int unsigned TEMP_BASE        = 34;
  localparam int unsigned TEMP_EXTRA_BASE  = 38;
  localparam int unsigned LAST_ITEM        = 18;

  // floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT for any 32-bit x
  localparam int unsigned DIV_SHIFT = 38;
  localparam logic [28:0] DIV_RECIP = 29'd274877907;

  localparam int unsigned SHORT_BASE [7] = '{38, 40, 42, 74, 78, 82, 84};
  localparam int unsigned LONG_BASE  [4] = '{50, 54, 58, 66};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  item_index;
    logic [63:0] item_value;
    logic        item_valid;
    logic        last_of_run;
  } out_word_t;

  // Frame verdict and captured fields, as they stand after the current byte
  typedef struct packed {
    status_e          status;
    logic [1:0][63:0] masks;
    logic [3:0][31:0] longs;
    logic [6:0][15:0] shorts;
    logic [5:0][15:0] temps;
    logic [2:0]       temp_count;
  } frame_sum_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* rtl/bmsd_frame.sv */
// ----------------------------------------------------------------------------
// bmsd_frame
// Per-byte frame tracking: position, CRC, header, field capture and verdict.
// ----------------------------------------------------------------------------
module bmsd_frame
  import bmsd_pkg::*;
#(
  parameter int unsigned MaxFrameLen = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_en_i,
  input  in_word_t   word_i,
  output frame_sum_t sum_o
);

  localparam int unsigned PW = $clog2(MaxFrameLen + 1);
  localparam int unsigned AW = (PW > 12) ? PW + 1 : 13;

  logic [PW-1:0]    pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       type_q, type_d, len_q, len_d, sens_q, sens_d, cells_q, cells_d;
  logic [15:0]      rcrc_q, rcrc_d, last2_q, last2_d;
  logic             bad_q, bad_d;
  logic [1:0][63:0] am_q, am_d;
  logic [3:0][31:0] lf_q, lf_d;
  logic [6:0][15:0] sf_q, sf_d;
  logic [5:0][15:0] tp_q, tp_d;

  logic [PW-1:0]    c_pos;
  logic [15:0]      c_crc, c_rcrc, c_last2;
  logic [7:0]       c_type, c_len, c_sens, c_cells;
  logic             c_bad;
  logic [5:0][15:0] c_tp;

  logic [AW-1:0] p, dyn, cells2, rel, flen, plen, minlen;
  logic [7:0]    b;
  logic          over;
  status_e       st;

  function automatic logic [15:0] put16(logic [15:0] f, logic [AW-1:0] pp,
                                        logic [AW-1:0] base, logic [7:0] v);
    logic [15:0]   r;
    logic [AW-1:0] d;
    r = f;
    d = pp - base;
    if (pp >= base) begin
      if (d == AW'(0)) r[7:0] = v;
      else if (d == AW'(1)) r[15:8] = v;
    end
    return r;
  endfunction

  always_comb begin
    b      = word_i.data_byte;
    over   = pos_q >= PW'(MaxFrameLen);
    p      = AW'(pos_q);
    cells2 = AW'({cells_q, 1'b0});
    dyn    = cells2 + AW'({sens_q, 1'b0});
    rel    = '0;

    c_pos = pos_q; c_crc = crc_q; c_rcrc = rcrc_q; c_last2 = last2_q;
    c_type = type_q; c_len = len_q; c_sens = sens_q; c_cells = cells_q;
    c_bad = bad_q; c_tp = tp_q;
    am_d = am_q; lf_d = lf_q; sf_d = sf_q;

    if (byte_en_i && !over) begin
      if (p == AW'(0) && b != SOF0_BYTE) c_bad = 1'b1;
      if (p == AW'(1) && b != SOF1_BYTE) c_bad = 1'b1;
      if (p == AW'(2)) c_type = b;
      if (p == AW'(5)) c_len = b;
      if (p == AW'(8)) c_sens = b;
      if (p == AW'(9)) c_cells = b;
      if (p >= AW'(1) && p < AW'(6) + AW'(len_q)) c_crc = crc_byte(crc_q, b);
      if (p >= AW'(6)) c_rcrc = put16(rcrc_q, p, AW'(6) + AW'(len_q), b);
      if (p >= AW'(HDR_LEN)) begin
        for (int i = 0; i < 2; i++) begin
          rel = p - AW'(HDR_LEN + 8 * i);
          if (p >= AW'(HDR_LEN + 8 * i) && rel < AW'(8))
            am_d[i][rel[2:0]*8 +: 8] = b;
        end
        for (int i = 0; i < 4; i++) begin
          rel = p - (AW'(LONG_BASE[i]) + dyn);
          if (p >= AW'(LONG_BASE[i]) + dyn && rel < AW'(4))
            lf_d[i][rel[1:0]*8 +: 8] = b;
        end
        for (int i = 0; i < 7; i++)
          sf_d[i] = put16(sf_q[i], p, AW'(SHORT_BASE[i]) + dyn, b);
        for (int i = 0; i < 4; i++)
          c_tp[i] = put16(tp_q[i], p, AW'(TEMP_BASE + 2 * i) + cells2, b);
        c_tp[4] = put16(tp_q[4], p, AW'(TEMP_BASE) + dyn, b);
        c_tp[5] = put16(tp_q[5], p, AW'(TEMP_BASE + 2) + dyn, b);
      end
      c_last2 = {last2_q[7:0], b};
      c_pos   = pos_q + PW'(1);
    end

    // Verdict on the frame as it stands with this byte
    flen   = p + AW'(1);
    plen   = AW'(HDR_LEN) + AW'(c_len);
    minlen = AW'(MIN_STATUS_LEN) + AW'({c_cells, 1'b0}) + AW'({c_sens, 1'b0});
    priority if (over || flen < AW'(HDR_LEN) || c_bad || c_last2 != EOF_WORD)
      st = STAT_FRAMING;
    else if (plen > flen || (c_type != TYPE_INFO && plen != flen))
      st = STAT_FRAMING;
    else if (c_crc != c_rcrc)
      st = STAT_CRC;
    else if (c_type == TYPE_STATUS) begin
      if (c_cells > 8'(MAX_CELLS) || c_sens > 8'(MAX_TEMP_SENSORS)) st = STAT_DECODE;
      else if (flen < minlen) st = STAT_DECODE;
      else st = STAT_OK;
    end else if (c_type == TYPE_INFO)
      st = STAT_INFO;
    else
      st = STAT_UNKNOWN;

    sum_o.status     = st;
    sum_o.masks      = am_d;
    sum_o.longs      = lf_d;
    sum_o.shorts     = sf_d;
    sum_o.temps      = c_tp;
    sum_o.temp_count = (c_sens > 8'(TEMP_SLOTS)) ? 3'(TEMP_SLOTS) : c_sens[2:0];

    // Drop the frame tracking state once the last byte is in; captured masks, longs and shorts are kept
    if (byte_en_i && word_i.frame_end) begin
      pos_d = '0; crc_d = CRC_INIT; rcrc_d = '0; last2_d = '0;
      type_d = '0; len_d = '0; sens_d = '0; cells_d = '0; bad_d = 1'b0; tp_d = '0;
    end else begin
      pos_d = c_pos; crc_d = c_crc; rcrc_d = c_rcrc; last2_d = c_last2;
      type_d = c_type; len_d = c_len; sens_d = c_sens; cells_d = c_cells;
      bad_d = c_bad; tp_d = c_tp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; crc_q <= CRC_INIT; rcrc_q <= '0; last2_q <= '0;
      type_q <= '0; len_q <= '0; sens_q <= '0; cells_q <= '0; bad_q <= 1'b0;
      tp_q <= '0;
    end else begin
      pos_q <= pos_d; crc_q <= crc_d; rcrc_q <= rcrc_d; last2_q <= last2_d;
      type_q <= type_d; len_q <= len_d; sens_q <= sens_d; cells_q <= cells_d;
      bad_q <= bad_d; tp_q <= tp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    am_q <= am_d;
    lf_q <= lf_d;
    sf_q <= sf_d;
  end

endmodule

/* rtl/bms_status_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// bms_status_frame_decoder_top
// Byte-stream decoder for 7E A1 framed battery status telemetry.
// ----------------------------------------------------------------------------
//  channel | direction | word       | handshake
//  in      | input     | in_word_t  | in_valid_i / in_stall_o
//  out     | output    | out_word_t | out_valid_o / out_stall_i
//
// One byte is taken every cycle unless a frame-end byte is stalled; framing,
// CRC and field capture finish in the cycle the byte is taken. A frame end
// gives one status word at once, or for a good status frame nineteen field
// words from a snapshot, one a cycle while the output is not stalled; the
// closing byte of the next frame is stalled until that run is done.
// Reset clears frame tracking, the run state and the output valid flag; no clearing pass.
// Out stalls hold the output word; in stalls only touch frame-end bytes.
module bms_status_frame_decoder_top
  import bmsd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

`include "bms_status_frame_decoder_top_assert.svh"

  frame_sum_t sum;
  logic       byte_en, frame_acc, can_load;

  // Snapshot of a good frame, read out while the next frame streams in
  logic [1:0][63:0] snap_am_q;
  logic [3:0][31:0] snap_lf_q;
  logic [6:0][15:0] snap_sf_q;
  logic [5:0][15:0] snap_tp_q;
  logic [2:0]       snap_tc_q;

  logic       run_q, run_d;
  logic [4:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_q, out_d;

  logic [31:0] div_in;
  logic [60:0] div_prod;
  logic [19:0] volt_mv;
  logic [63:0] run_value;
  logic        run_valid;
  logic [4:0]  tslot;

  // A word can enter the output register when it is empty or being taken
  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_i && in_word_i.frame_end && (run_q || !can_load);
  assign byte_en    = in_valid_i && !in_stall_o;
  assign frame_acc  = byte_en && in_word_i.frame_end;

  bmsd_frame #(
    .MaxFrameLen(MAX_FRAME_LEN)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(byte_en),
    .word_i   (in_word_i),
    .sum_o    (sum)
  );

  // Field word for the current run slot
  always_comb begin
    div_in    = (idx_q == 5'd8) ? snap_lf_q[1] : snap_lf_q[0];
    div_prod  = 61'(div_in) * 61'(DIV_RECIP);
    volt_mv   = {1'b0, snap_sf_q[0], 3'b000} + {3'b000, snap_sf_q[0], 1'b0};
    tslot     = idx_q - 5'd13;
    run_value = '0;
    run_valid = 1'b1;
    priority if (idx_q == 5'd0)  run_value = 64'(volt_mv);
    else if (idx_q <= 5'd6)      run_value = 64'(snap_sf_q[idx_q[2:0]]);
    else if (idx_q <= 5'd8)      run_value = 64'(div_prod[60:DIV_SHIFT]);
    else if (idx_q <= 5'd10)     run_value = 64'(snap_lf_q[2'(idx_q - 5'd7)]);
    else if (idx_q <= 5'd12)     run_value = snap_am_q[idx_q[0] ? 1'b0 : 1'b1];
    else if (idx_q <= 5'd16) begin
      if (tslot < 5'(snap_tc_q)) run_value = 64'(snap_tp_q[tslot[2:0]]);
      else run_valid = 1'b0;
    end else                     run_value = 64'(snap_tp_q[tslot[2:0]]);
  end

  always_comb begin
    run_d       = run_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (frame_acc) begin
      if (sum.status == STAT_OK) begin
        run_d = 1'b1;
        idx_d = '0;
      end else begin
        // Single status word for every other verdict
        out_valid_d       = 1'b1;
        out_d.status      = sum.status;
        out_d.item_index  = '0;
        out_d.item_value  = '0;
        out_d.item_valid  = 1'b0;
        out_d.last_of_run = 1'b1;
      end
    end else if (run_q && can_load) begin
      out_valid_d       = 1'b1;
      out_d.status      = STAT_OK;
      out_d.item_index  = idx_q;
      out_d.item_value  = run_value;
      out_d.item_valid  = run_valid;
      out_d.last_of_run = idx_q == 5'(LAST_ITEM);
      idx_d             = idx_q + 5'd1;
      if (idx_q == 5'(LAST_ITEM)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (frame_acc && sum.status == STAT_OK) begin
      snap_am_q <= sum.masks;
      snap_lf_q <= sum.longs;
      snap_sf_q <= sum.shorts;
      snap_tp_q <= sum.temps;
      snap_tc_q <= sum.temp_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `BMSD_ASSERT_IMP(a_no_end_during_run, clk_i, rst_ni, frame_acc, !run_q)
  `BMSD_ASSERT_IMP(a_idx_in_range, clk_i, rst_ni, run_q, idx_q <= 5'(LAST_ITEM))
  `BMSD_ASSERT_NXT(a_run_ends, clk_i, rst_ni,
                   run_q && can_load && idx_q == 5'(LAST_ITEM), !run_q)
  `BMSD_ASSERT_IMP(a_last_ok_is_final, clk_i, rst_ni,
                   out_valid_q && out_q.status == STAT_OK && out_q.last_of_run,
                   out_q.item_index == 5'(LAST_ITEM))

endmodule
